// ===== src/stk_pkg.sv =====
`default_nettype none

package stk_pkg;

   localparam int ID_W    = 31;
   localparam int PRICE_W = 31;
   localparam int NAME_W  = 16;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int DEPTH_W = 5;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [STAT_W-1:0] status_type;

   localparam cmd_type CMD_PUSH    = 2'd0;
   localparam cmd_type CMD_POP     = 2'd1;
   localparam cmd_type CMD_EXTRACT = 2'd2;

   localparam status_type ST_OK   = 2'd0;
   localparam status_type ST_MISS = 2'd1;
   localparam status_type ST_FULL = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [PRICE_W-1:0] price;
      logic [NAME_W-1:0]  name_ref;
   } rec_type;

   typedef struct packed {
      status_type         status;
      rec_type            rec;
      logic [DEPTH_W-1:0] depth;
   } res_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_SEARCH,
      S_SHIFT,
      S_RESULT
   } seq_state_type;

endpackage

`default_nettype wire

// ===== src/stack_with_extract_by_key.sv =====
`default_nettype none

// Channel  Direction  Handshake              Fields
// req      in         req_valid, req_stall   cmd, item_id, item_price, item_name_ref
// rsp      out        rsp_valid, rsp_stall   status, out_id, out_price, out_name_ref, depth_now
//
// A push goes from S_IDLE straight to S_RESULT, a pop through S_POP, and an extract through S_SEARCH and S_SHIFT:
// the search reads one record per cycle from the single read port of the record memory,
// and the records above a hit are then moved down one per cycle through that same port.
// Reset empties the stack at once; the record memory itself is not cleared.
// A new request is taken while the previous result still waits in the output register.

module stack_with_extract_by_key #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [stk_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic [stk_pkg::ID_W-1:0]    req_item_id,
   input  wire logic [stk_pkg::PRICE_W-1:0] req_item_price,
   input  wire logic [stk_pkg::NAME_W-1:0]  req_item_name_ref,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [stk_pkg::STAT_W-1:0]      rsp_status,
   output logic [stk_pkg::ID_W-1:0]        rsp_out_id,
   output logic [stk_pkg::PRICE_W-1:0]     rsp_out_price,
   output logic [stk_pkg::NAME_W-1:0]      rsp_out_name_ref,
   output logic [stk_pkg::DEPTH_W-1:0]     rsp_depth_now
);
   import stk_pkg::*;

   logic    seq_ready, seq_done, start, out_free;
   rec_type req_rec;
   res_type seq_res;
   logic    rsp_valid_ff;
   res_type rsp_res_ff;

   assign req_rec.id       = req_item_id;
   assign req_rec.price    = req_item_price;
   assign req_rec.name_ref = req_item_name_ref;

   assign req_stall = !seq_ready;
   assign start     = req_valid && seq_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   stk_seq #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_cmd  (req_cmd),
      .req_rec  (req_rec),
      .out_free (out_free),
      .ready    (seq_ready),
      .done     (seq_done),
      .res      (seq_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (seq_done) begin
         rsp_res_ff <= seq_res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_res_ff.status;
   assign rsp_out_id       = rsp_res_ff.rec.id;
   assign rsp_out_price    = rsp_res_ff.rec.price;
   assign rsp_out_name_ref = rsp_res_ff.rec.name_ref;
   assign rsp_depth_now    = rsp_res_ff.depth;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      seq_done |-> (!rsp_valid_ff || !rsp_stall))
      else $error("A result was loaded over one that had not been transferred.");

endmodule

`default_nettype wire

// ===== src/stk_mem.sv =====
`default_nettype none

module stk_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire stk_pkg::rec_type wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output stk_pkg::rec_type      rd_data
);
   import stk_pkg::*;

   rec_type mem [DEPTH];
   rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/stk_seq.sv =====
`default_nettype none

module stk_seq #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire stk_pkg::cmd_type req_cmd,
   input  wire stk_pkg::rec_type req_rec,
   input  wire logic             out_free,
   output logic                  ready,
   output logic                  done,
   output stk_pkg::res_type      res
);
   import stk_pkg::*;

   localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);

   seq_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [ID_W-1:0]  key_ff, key_in;
   res_type          res_ff, res_in;

   logic [CNT_W-1:0] cnt_inc, cnt_dec, idx_inc, idx_inc2, idx_dec;

   logic             mem_we, mem_re;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   rec_type          mem_wdata, mem_rdata;

   assign cnt_inc  = count_ff + 1'b1;
   assign cnt_dec  = count_ff - 1'b1;
   assign idx_inc  = idx_ff + 1'b1;
   assign idx_inc2 = idx_ff + 2'd2;
   assign idx_dec  = idx_ff - 1'b1;

   stk_mem #(
      .DEPTH (STACK_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
      key_ff <= key_in;
      res_ff <= res_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      key_in    = key_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_waddr = count_ff[AW-1:0];
      mem_wdata = req_rec;
      mem_re    = 1'b0;
      mem_raddr = idx_ff[AW-1:0];
      done      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in        = req_rec.id;
               res_in.status = ST_MISS;
               res_in.rec    = '0;
               res_in.depth  = DEPTH_W'(count_ff);
               state_in      = S_RESULT;
               case (req_cmd)
                  CMD_PUSH: begin
                     if (count_ff == FULL_COUNT) begin
                        res_in.status = ST_FULL;
                     end else begin
                        mem_we        = 1'b1;
                        count_in      = cnt_inc;
                        res_in.status = ST_OK;
                        res_in.depth  = DEPTH_W'(cnt_inc);
                     end
                  end
                  CMD_POP: begin
                     if (count_ff != '0) begin
                        mem_re    = 1'b1;
                        mem_raddr = cnt_dec[AW-1:0];
                        count_in  = cnt_dec;
                        state_in  = S_POP;
                     end
                  end
                  CMD_EXTRACT: begin
                     if (count_ff != '0) begin
                        mem_re    = 1'b1;
                        mem_raddr = cnt_dec[AW-1:0];
                        idx_in    = cnt_dec;
                        state_in  = S_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            res_in.status = ST_OK;
            res_in.rec    = mem_rdata;
            res_in.depth  = DEPTH_W'(count_ff);
            state_in      = S_RESULT;
         end
         S_SEARCH: begin
            if (mem_rdata.id == key_ff) begin
               res_in.status = ST_OK;
               res_in.rec    = mem_rdata;
               res_in.depth  = DEPTH_W'(cnt_dec);
               count_in      = cnt_dec;
               if (idx_inc == count_ff) begin
                  state_in = S_RESULT;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = idx_inc[AW-1:0];
                  state_in  = S_SHIFT;
               end
            end else if (idx_ff == '0) begin
               state_in = S_RESULT;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = idx_dec[AW-1:0];
               idx_in    = idx_dec;
            end
         end
         S_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
            mem_wdata = mem_rdata;
            if (idx_inc == count_ff) begin
               state_in = S_RESULT;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = idx_inc2[AW-1:0];
               idx_in    = idx_inc;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign ready = (state_ff == S_IDLE);
   assign res   = res_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("Record count exceeds the capacity.");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start && req_cmd == CMD_PUSH && count_ff != FULL_COUNT)
      |=> (count_ff == $past(cnt_inc)))
      else $error("A push that fits did not add a record.");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start && req_cmd == CMD_POP && count_ff == '0)
      |=> (count_ff == '0 && res_ff.status == ST_MISS))
      else $error("A pop from an empty stack was not reported as a miss.");

   a_shift_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (idx_inc <= count_ff))
      else $error("Compaction has run past the top of the stack.");

endmodule

`default_nettype wire
